@@ design/utf8_validating_decoder_defines.svh @@
// assertion macros shared by the utf8 decoder rtl
`ifndef UTF8_VALIDATING_DECODER_DEFINES_SVH
`define UTF8_VALIDATING_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define UVD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uvd assertion failed");

// next-cycle implication, checked outside reset
`define UVD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uvd assertion failed");

`endif

@@ design/uvd_pkg.sv @@
// shared types and constants of the utf8 validating decoder
`default_nettype none
package uvd_pkg;

    localparam int CP_W = 21;
    localparam int CMD_FIFO_DEPTH = 4;

    localparam logic [CP_W-1:0] REPL_CHAR  = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_SCALAR = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;

    // one decoded byte: some replacement chars, then an optional tail result
    typedef struct packed {
        logic            eos;
        logic            tail_repl;
        logic [CP_W-1:0] tail_cp;
        logic            has_tail;
        logic [1:0]      n_flush;
    } t_cmd;

endpackage
`default_nettype wire

@@ design/uvd_front.sv @@
// byte classifier and sequence state, turns each byte that yields output into a command
`default_nettype none
module uvd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_eos,
    input  wire logic          i_q_full,
    output logic               o_push,
    output uvd_pkg::t_cmd      o_cmd
);
    import uvd_pkg::*;

    localparam logic [CP_W-1:0] MIN_2B = 21'h000080;
    localparam logic [CP_W-1:0] MIN_3B = 21'h000800;
    localparam logic [CP_W-1:0] MIN_4B = 21'h010000;

    logic [2:0]      r_exp;
    logic [1:0]      r_seen;
    logic [CP_W-1:0] r_val;
    logic [2:0]      n_exp;
    logic [1:0]      n_seen;
    logic [CP_W-1:0] n_val;

    logic            pending;
    logic            is_cont;
    logic [2:0]      seen;
    logic [CP_W-1:0] acc;
    logic            complete;
    logic            bad;
    logic [2:0]      lead_len;
    logic            accept;
    t_cmd            cmd;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign pending = (r_exp != 3'd0);
    assign is_cont = (i_byte[7:6] == 2'b10);
    assign seen    = {1'b0, r_seen} + 3'd1;
    assign acc     = {r_val[CP_W-7:0], i_byte[5:0]};
    assign complete = ((seen + 3'd1) >= r_exp);

    always_comb begin
        bad = (acc >= SURR_LO && acc <= SURR_HI) || (acc > MAX_SCALAR);
        case (r_exp)
            3'd2: bad = bad || (acc < MIN_2B);
            3'd3: bad = bad || (acc < MIN_3B);
            3'd4: bad = bad || (acc < MIN_4B);
            default: bad = bad;
        endcase
    end

    always_comb begin
        if (!i_byte[7]) begin
            lead_len = 3'd1;
        end else if (i_byte[7:5] == 3'b110) begin
            lead_len = 3'd2;
        end else if (i_byte[7:4] == 4'b1110) begin
            lead_len = 3'd3;
        end else if (i_byte[7:3] == 5'b11110) begin
            lead_len = 3'd4;
        end else begin
            lead_len = 3'd0;
        end
    end

    always_comb begin
        cmd           = '0;
        cmd.eos       = i_eos;
        cmd.tail_cp   = REPL_CHAR;
        cmd.tail_repl = 1'b1;
        n_exp  = r_exp;
        n_seen = r_seen;
        n_val  = r_val;
        if (pending && is_cont) begin
            if (complete) begin
                cmd.has_tail  = 1'b1;
                cmd.tail_repl = bad;
                cmd.tail_cp   = bad ? REPL_CHAR : acc;
                n_exp = 3'd0;
            end else begin
                n_seen = seen[1:0];
                n_val  = acc;
                if (i_eos) begin
                    // string ends mid-sequence: lead plus every continuation seen
                    cmd.n_flush = seen[1:0] + 2'd1;
                end
            end
        end else begin
            if (pending) begin
                cmd.n_flush = r_seen + 2'd1;
            end
            n_exp = 3'd0;
            case (lead_len)
                3'd1: begin
                    cmd.has_tail  = 1'b1;
                    cmd.tail_repl = 1'b0;
                    cmd.tail_cp   = {{(CP_W-8){1'b0}}, i_byte};
                end
                3'd2, 3'd3, 3'd4: begin
                    if (i_eos) begin
                        cmd.has_tail = 1'b1;
                    end else begin
                        n_exp  = lead_len;
                        n_seen = 2'd0;
                        case (lead_len)
                            3'd2:    n_val = {{(CP_W-5){1'b0}}, i_byte[4:0]};
                            3'd3:    n_val = {{(CP_W-4){1'b0}}, i_byte[3:0]};
                            default: n_val = {{(CP_W-3){1'b0}}, i_byte[2:0]};
                        endcase
                    end
                end
                default: begin
                    cmd.has_tail = 1'b1;
                end
            endcase
        end
        if (i_eos) begin
            n_exp  = 3'd0;
            n_seen = 2'd0;
            n_val  = '0;
        end
        if (n_exp == 3'd0) begin
            n_seen = 2'd0;
            n_val  = '0;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.has_tail || (cmd.n_flush != 2'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp  <= 3'd0;
            r_seen <= 2'd0;
            r_val  <= '0;
        end else if (accept) begin
            r_exp  <= n_exp;
            r_seen <= n_seen;
            r_val  <= n_val;
        end
    end

endmodule
`default_nettype wire

@@ design/uvd_fifo.sv @@
// short command queue between the classifier and the expander
`default_nettype none
module uvd_fifo #(
    parameter int DEPTH = uvd_pkg::CMD_FIFO_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire uvd_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_valid,
    output uvd_pkg::t_cmd      o_cmd
);
    import uvd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ design/uvd_back.sv @@
// expands commands into code points, one per cycle while the output is not stalled, behind an output register
`default_nettype none
module uvd_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire uvd_pkg::t_cmd     i_cmd,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [uvd_pkg::CP_W-1:0] o_cp,
    output logic                   o_repl,
    output logic                   o_last
);
    import uvd_pkg::*;

    logic [1:0]      r_idx;
    logic            r_valid;
    logic [CP_W-1:0] r_cp;
    logic            r_repl;
    logic            r_last;
    logic [2:0]      total;
    logic            load;
    logic            is_last;
    logic            in_flush;

    assign total    = {1'b0, i_cmd.n_flush} + {2'b00, i_cmd.has_tail};
    assign load     = i_valid && (!r_valid || i_ready);
    assign is_last  = (({1'b0, r_idx} + 3'd1) == total);
    assign in_flush = (r_idx < i_cmd.n_flush);
    assign o_pop    = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp   <= in_flush ? REPL_CHAR : i_cmd.tail_cp;
            r_repl <= in_flush ? 1'b1 : i_cmd.tail_repl;
            r_last <= is_last && i_cmd.eos;
        end
    end

    assign o_valid = r_valid;
    assign o_cp    = r_cp;
    assign o_repl  = r_repl;
    assign o_last  = r_last;

endmodule
`default_nettype wire

@@ design/utf8_validating_decoder.sv @@
// a completed code point passes through the command queue and then the expander's output register
// throughput: one byte per cycle while each byte yields at most one code point and the output is not stalled
// a byte that yields k code points holds the expander for k transfers (k up to 4);
// the 4-entry command queue absorbs such bursts before input stalls
// reset: synchronous active-low, clears sequence state, queue and output valid
`default_nettype none
`include "utf8_validating_decoder_defines.svh"
module utf8_validating_decoder #(
    parameter int FIFO_DEPTH = uvd_pkg::CMD_FIFO_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // end_of_string
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic             m_axis_tuser,   // replaced
    output logic             m_axis_tlast    // final_result
);
    import uvd_pkg::*;

    // classifier to queue
    logic            push;
    t_cmd            push_cmd;
    logic            q_full;
    // queue to expander
    logic            q_valid;
    t_cmd            q_cmd;
    logic            pop;
    logic [CP_W-1:0] out_cp;

    // front: holds the pending sequence and classifies each byte
    uvd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_byte   (s_axis_tdata),
        .i_eos    (s_axis_tlast),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // queue lets the expander stall without stopping byte intake at once
    uvd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // back: one code point per transfer, replacement chars first
    uvd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_cp    (out_cp),
        .o_repl  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_cp};

    // a final byte always leaves at least one code point queued
    `UVD_ASSERT_IMPL(a_eos_pushes, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, push)
    // a non-replaced code point is a valid scalar value
    `UVD_ASSERT_IMPL(a_scalar_ok, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, (out_cp <= MAX_SCALAR) && ((out_cp < SURR_LO) || (out_cp > SURR_HI)))
    // a replaced result always carries the replacement character
    `UVD_ASSERT_IMPL(a_repl_char, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, out_cp == REPL_CHAR)

endmodule
`default_nettype wire
